// ===== src/hed_pkg.sv =====
// shared types, character codes and entity tables of the html entity decoder
// used by hed_front, hed_fifo, hed_back and html_entity_decoder_unit; no dependencies
package hed_pkg;

  typedef enum logic [5:0] {
    MODE_IDLE      = 6'b000001,
    MODE_NAME      = 6'b000010,
    MODE_NUM       = 6'b000100,
    MODE_SKIP_SEMI = 6'b001000,
    MODE_TAG       = 6'b010000,
    MODE_SKIP_GT   = 6'b100000
  } mode_e;

  typedef enum logic [1:0] {
    JOB_BYTE = 2'd0,
    JOB_CODE = 2'd1,
    JOB_END  = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [30:0] value;
  } job_t;

  localparam int unsigned NumNames = 5;

  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharLt    = 8'h3C;
  localparam logic [7:0] CharGt    = 8'h3E;
  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharNl    = 8'h0A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharNul   = 8'h00;

  localparam logic [30:0] CodeMax = 31'h7FFF_FFFF;

  // lt, gt, amp, apos, quot
  function automatic logic [7:0] name_char_at(input logic [2:0] k, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      3'd0: begin
        case (pos)
          3'd0: c = 8'h6C;
          3'd1: c = 8'h74;
          3'd2: c = CharSemi;
          default: c = 8'h00;
        endcase
      end
      3'd1: begin
        case (pos)
          3'd0: c = 8'h67;
          3'd1: c = 8'h74;
          3'd2: c = CharSemi;
          default: c = 8'h00;
        endcase
      end
      3'd2: begin
        case (pos)
          3'd0: c = 8'h61;
          3'd1: c = 8'h6D;
          3'd2: c = 8'h70;
          3'd3: c = CharSemi;
          default: c = 8'h00;
        endcase
      end
      3'd3: begin
        case (pos)
          3'd0: c = 8'h61;
          3'd1: c = 8'h70;
          3'd2: c = 8'h6F;
          3'd3: c = 8'h73;
          3'd4: c = CharSemi;
          default: c = 8'h00;
        endcase
      end
      3'd4: begin
        case (pos)
          3'd0: c = 8'h71;
          3'd1: c = 8'h75;
          3'd2: c = 8'h6F;
          3'd3: c = 8'h74;
          3'd4: c = CharSemi;
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] name_len(input logic [2:0] k);
    logic [2:0] l;
    case (k)
      3'd0: l = 3'd3;
      3'd1: l = 3'd3;
      3'd2: l = 3'd4;
      3'd3: l = 3'd5;
      3'd4: l = 3'd5;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] name_result(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0: c = CharLt;
      3'd1: c = CharGt;
      3'd2: c = CharAmp;
      3'd3: c = 8'h27;
      3'd4: c = 8'h22;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "br>"
  function automatic logic [7:0] tag_char_at(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = 8'h62;
      3'd1: c = 8'h72;
      3'd2: c = CharGt;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== src/hed_front.sv =====
// parser front end: takes one text byte per request and turns it into at most one output job
// depends on hed_pkg
module hed_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  output logic              push_o,
  output hed_pkg::job_t     job_o
);

  hed_pkg::mode_e mode_q, mode_d;
  logic [2:0]     pos_q, pos_d;
  logic [4:0]     mask_q, mask_d;
  logic [30:0]    code_q, code_d;
  logic           dig_q, dig_d;

  logic           go_idle;
  hed_pkg::mode_e idle_mode;
  logic [4:0]     hit;
  logic [4:0]     fin;
  logic [2:0]     fin_k;
  logic [34:0]    code_x10;
  logic           is_digit;

  assign is_digit = (byte_i >= hed_pkg::CharZero) && (byte_i <= hed_pkg::CharNine);
  assign code_x10 = ({4'd0, code_q} << 3) + ({4'd0, code_q} << 1)
                    + {27'd0, byte_i - hed_pkg::CharZero};

  always_comb begin
    fin_k = 3'd0;
    for (int k = 0; k < hed_pkg::NumNames; k++) begin
      hit[k] = mask_q[k] && (pos_q < hed_pkg::name_len(3'(k)))
               && (hed_pkg::name_char_at(3'(k), pos_q) == byte_i);
      fin[k] = hit[k] && ((pos_q + 3'd1) == hed_pkg::name_len(3'(k)));
      if (fin[k]) begin
        fin_k = 3'(k);
      end
    end
  end

  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    mask_d    = mask_q;
    code_d    = code_q;
    dig_d     = dig_q;
    go_idle   = 1'b0;
    idle_mode = hed_pkg::MODE_IDLE;
    push_o    = 1'b0;
    job_o     = '{kind: hed_pkg::JOB_BYTE, value: 31'd0};
    if (accept_i) begin
      if (byte_i == hed_pkg::CharNul) begin
        go_idle = 1'b1;
        push_o  = 1'b1;
        job_o   = '{kind: hed_pkg::JOB_END, value: 31'd0};
      end else begin
        case (mode_q)
          hed_pkg::MODE_NAME: begin
            if (pos_q == 3'd0 && byte_i == hed_pkg::CharHash) begin
              mode_d = hed_pkg::MODE_NUM;
              code_d = 31'd0;
              dig_d  = 1'b1;
            end else if (hit == 5'd0) begin
              go_idle = 1'b1;
              if (byte_i != hed_pkg::CharSemi) begin
                idle_mode = hed_pkg::MODE_SKIP_SEMI;
              end
            end else if (fin != 5'd0) begin
              push_o  = 1'b1;
              job_o   = '{kind: hed_pkg::JOB_BYTE,
                          value: {23'd0, hed_pkg::name_result(fin_k)}};
              go_idle = 1'b1;
            end else begin
              pos_d  = pos_q + 3'd1;
              mask_d = hit;
            end
          end
          hed_pkg::MODE_NUM: begin
            if (byte_i == hed_pkg::CharSemi) begin
              push_o  = (code_q != 31'd0);
              job_o   = '{kind: hed_pkg::JOB_CODE, value: code_q};
              go_idle = 1'b1;
            end else if (is_digit) begin
              if (dig_q) begin
                code_d = (code_x10[34:31] != 4'd0) ? hed_pkg::CodeMax : code_x10[30:0];
              end
            end else begin
              dig_d = 1'b0;
            end
          end
          hed_pkg::MODE_SKIP_SEMI: begin
            if (byte_i == hed_pkg::CharSemi) begin
              go_idle = 1'b1;
            end
          end
          hed_pkg::MODE_TAG: begin
            if (pos_q < 3'd3 && hed_pkg::tag_char_at(pos_q) == byte_i) begin
              if (pos_q == 3'd2) begin
                push_o  = 1'b1;
                job_o   = '{kind: hed_pkg::JOB_BYTE, value: {23'd0, hed_pkg::CharNl}};
                go_idle = 1'b1;
              end else begin
                pos_d = pos_q + 3'd1;
              end
            end else if (byte_i == hed_pkg::CharGt) begin
              go_idle = 1'b1;
            end else begin
              go_idle   = 1'b1;
              idle_mode = hed_pkg::MODE_SKIP_GT;
            end
          end
          hed_pkg::MODE_SKIP_GT: begin
            if (byte_i == hed_pkg::CharGt) begin
              go_idle = 1'b1;
            end
          end
          default: begin
            if (byte_i == hed_pkg::CharAmp) begin
              go_idle   = 1'b1;
              idle_mode = hed_pkg::MODE_NAME;
            end else if (byte_i == hed_pkg::CharLt) begin
              go_idle   = 1'b1;
              idle_mode = hed_pkg::MODE_TAG;
            end else begin
              push_o = 1'b1;
              job_o  = '{kind: hed_pkg::JOB_BYTE, value: {23'd0, byte_i}};
            end
          end
        endcase
      end
      if (go_idle) begin
        mode_d = idle_mode;
        pos_d  = 3'd0;
        mask_d = (idle_mode == hed_pkg::MODE_NAME) ? 5'h1F : 5'h00;
        code_d = 31'd0;
        dig_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= hed_pkg::MODE_IDLE;
      pos_q  <= 3'd0;
      mask_q <= 5'd0;
      code_q <= 31'd0;
      dig_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      mask_q <= mask_d;
      code_q <= code_d;
      dig_q  <= dig_d;
    end
  end

endmodule

// ===== src/hed_fifo.sv =====
// short job queue between parser front end and byte emitter
// depends on hed_pkg
module hed_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hed_pkg::job_t data_i,
  output logic          full_o,
  output logic          valid_o,
  output hed_pkg::job_t data_o,
  input  logic          pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  hed_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== src/hed_back.sv =====
// byte emitter: expands queued jobs into output bytes, utf-8 codes take up to six
// depends on hed_pkg
module hed_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  hed_pkg::job_t head_i,
  output logic          pop_o,
  output logic [7:0]    tdata_o,
  output logic          tlast_o,
  output logic          tuser_o,
  output logic          tvalid_o,
  input  logic          tready_i
);

  logic [2:0]  idx_q, idx_d;
  logic        tvalid_q;
  logic [7:0]  tdata_q;
  logic        tlast_q, tuser_q;

  logic [2:0]  len;
  logic [2:0]  grp;
  logic [37:0] ext;
  logic [7:0]  grp_bits;
  logic [7:0]  lead;
  logic [7:0]  byte_val;
  logic        load;
  logic        last;

  always_comb begin
    if (head_i.kind != hed_pkg::JOB_CODE || head_i.value < 31'h80) begin
      len = 3'd1;
    end else if (head_i.value < 31'h800) begin
      len = 3'd2;
    end else if (head_i.value < 31'h1_0000) begin
      len = 3'd3;
    end else if (head_i.value < 31'h20_0000) begin
      len = 3'd4;
    end else if (head_i.value < 31'h400_0000) begin
      len = 3'd5;
    end else begin
      len = 3'd6;
    end
  end

  assign grp = len - 3'd1 - idx_q;
  assign ext = {7'd0, head_i.value};

  always_comb begin
    case (grp)
      3'd0: grp_bits = ext[7:0];
      3'd1: grp_bits = ext[13:6];
      3'd2: grp_bits = ext[19:12];
      3'd3: grp_bits = ext[25:18];
      3'd4: grp_bits = ext[31:24];
      3'd5: grp_bits = ext[37:30];
      default: grp_bits = 8'h00;
    endcase
  end

  always_comb begin
    case (len)
      3'd2: lead = 8'hC0;
      3'd3: lead = 8'hE0;
      3'd4: lead = 8'hF0;
      3'd5: lead = 8'hF8;
      3'd6: lead = 8'hFC;
      default: lead = 8'h00;
    endcase
  end

  always_comb begin
    case (head_i.kind)
      hed_pkg::JOB_CODE: begin
        if (len == 3'd1) begin
          byte_val = head_i.value[7:0];
        end else if (idx_q == 3'd0) begin
          byte_val = lead | grp_bits;
        end else begin
          byte_val = {2'b10, grp_bits[5:0]};
        end
      end
      hed_pkg::JOB_END: byte_val = 8'h00;
      default:          byte_val = head_i.value[7:0];
    endcase
  end

  assign load  = head_valid_i && (!tvalid_q || tready_i);
  assign last  = (idx_q == len - 3'd1);
  assign pop_o = load && last;
  assign idx_d = pop_o ? 3'd0 : (load ? idx_q + 3'd1 : idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
      idx_q    <= 3'd0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        tvalid_q <= 1'b1;
      end else if (tready_i) begin
        tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tdata_q <= byte_val;
      tlast_q <= last;
      tuser_q <= (head_i.kind == hed_pkg::JOB_END);
    end
  end

  assign tvalid_o = tvalid_q;
  assign tdata_o  = tdata_q;
  assign tlast_o  = tlast_q;
  assign tuser_o  = tuser_q;

endmodule

// ===== src/html_entity_decoder_unit.sv =====
// top level of the html entity decoder: parser front end, job queue, byte emitter
// depends on hed_pkg, hed_front, hed_fifo, hed_back
//
// input stream: one text byte per request; a zero byte ends the string and
//   returns the parser to plain text
// output stream: decoded bytes; tlast marks the final byte caused by one
//   input byte, tuser marks the single zero result that reports end of string
// input bytes that open or continue an entity or a tag give no output
// a byte is taken every cycle while the job queue has room; the parser
//   finishes its work in the cycle of the request
// path: an accepted byte's job is written into the job queue, and its output
//   byte is then registered in the output register
// throughput: one output byte per cycle while the receiver is ready; a numeric
//   entity gives 1 to 6 utf-8 bytes, and the emitter holds its queue entry until the last one
// receiver stall: the output register holds, the queue fills and then
//   s_axis_tready_o drops; nothing is lost
// reset: parser goes to plain text, queue and output register empty
module html_entity_decoder_unit #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] text_byte
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,
  output logic       m_axis_tuser_o,   // [0] string_end
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i
);

  logic          accept;
  logic          push;
  hed_pkg::job_t push_job;
  logic          full;
  logic          head_valid;
  hed_pkg::job_t head_job;
  logic          pop;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  hed_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .push_o   (push),
    .job_o    (push_job)
  );

  hed_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .valid_o (head_valid),
    .data_o  (head_job),
    .pop_i   (pop)
  );

  hed_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .tdata_o      (m_axis_tdata_o),
    .tlast_o      (m_axis_tlast_o),
    .tuser_o      (m_axis_tuser_o),
    .tvalid_o     (m_axis_tvalid_o),
    .tready_i     (m_axis_tready_i)
  );

endmodule
